// ===== hw/rtl/peer_relay_debt_scheduler_assert.svh =====
// Assertion macros for the peer relay debt scheduler.
// Used by prds_dpath, the RTL file that holds concurrent assertions; no other dependencies.
`ifndef PEER_RELAY_DEBT_SCHEDULER_ASSERT_SVH
`define PEER_RELAY_DEBT_SCHEDULER_ASSERT_SVH
`ifndef SYNTH
`define PRDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PRDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PRDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PRDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/prds_pkg.sv =====
// Shared constants and types of the peer relay debt scheduler.
// No dependencies.
package prds_pkg;
  localparam int MAX_PEERS_DEF = 32;
  localparam int ADDR_W = 32;
  localparam int PORT_W = 16;
  localparam int CHUNK_W = 16;
  localparam int DEBT_W = 8;
  localparam int MAXD_W = 7;
  localparam int CMD_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_DATA = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HELLO = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BYE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SPL_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPL_PORT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEBT = 2'd2;

  localparam logic [MAXD_W-1:0] MAX_DEBT_RST = 7'd32;
  localparam logic [DEBT_W-1:0] DEBT_MIN = 8'h80;

  typedef struct packed {
    logic [ADDR_W-1:0] ip;
    logic [PORT_W-1:0] port;
    logic [DEBT_W-1:0] debt;
  } entry_t;

  typedef struct packed {
    logic load_in;
    logic idx_clr;
    logic idx_inc;
    logic idx_feed;
    logic rd_idx;
    logic rd_idx1;
    logic wr_shift;
    logic wr_add;
    logic wr_dec;
    logic wr_inc;
    logic cnt_dec;
    logic feed_inc;
    logic feed_clr;
    logic set_prev;
    logic emit_send;
    logic emit_done;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic is_splitter;
    logic match;
    logic idx_lt_cnt;
    logic idx1_lt_cnt;
    logic feed_burst;
    logic rr_ok;
    logic ev;
    logic out_free;
  } dp_sts_t;
endpackage

// ===== hw/rtl/prds_in_if.sv =====
// Input channel interface of the peer relay debt scheduler.
// Depends on prds_pkg for field widths.
interface prds_in_if;
  logic valid;
  logic ready;
  logic [prds_pkg::CMD_W-1:0] cmd;
  logic [prds_pkg::ADDR_W-1:0] sender_addr;
  logic [prds_pkg::PORT_W-1:0] sender_port;
  logic [prds_pkg::CHUNK_W-1:0] seq_num;
  modport source (output valid, cmd, sender_addr, sender_port, seq_num, input ready);
  modport sink (input valid, cmd, sender_addr, sender_port, seq_num, output ready);
endinterface

// ===== hw/rtl/prds_out_if.sv =====
// Result channel interface of the peer relay debt scheduler.
// Depends on prds_pkg for field widths.
interface prds_out_if;
  logic valid;
  logic ready;
  logic kind;
  logic [prds_pkg::ADDR_W-1:0] dest_addr;
  logic [prds_pkg::PORT_W-1:0] dest_port;
  logic [prds_pkg::CHUNK_W-1:0] fwd_chunk;
  logic evicted;
  logic was_data;
  logic table_full;
  logic last;
  modport source (output valid, kind, dest_addr, dest_port, fwd_chunk, evicted, was_data,
                  table_full, last, input ready);
  modport sink (input valid, kind, dest_addr, dest_port, fwd_chunk, evicted, was_data,
                table_full, last, output ready);
endinterface

// ===== hw/rtl/peer_relay_debt_scheduler.sv =====
// Peer relay debt scheduler.
// An input item on in_ch is a data chunk, hello or goodbye from a peer or the splitter.
// Each item yields zero or more send results (kind 0) and then one done result
// (kind 1, last 1) on out_ch. The splitter address, splitter port and debt limit are
// written through cfg_we, cfg_idx and cfg_data; the user must write them only while
// the block is idle, which the block itself does not enforce. Items are taken one
// at a time: in_ch.ready is high only between items. The peer table is searched one
// entry at a time, each entry read and then compared. Each send reads the peer's
// entry, then emits the result and updates its debt; an evicted peer is compacted
// out by moving each later table entry down one place. A splitter chunk bursts up
// to MAX_PEERS - 1 sends before its round-robin send. An unused command goes
// straight to its done result; a burst that evicts peers takes longest.
// A result sits in an output register; when out_ch stalls, the sequencer waits at
// its next send or done step and nothing is lost.
// Synchronous reset empties the table, clears the forward index and the previous
// chunk flag, and restores the register defaults; no clearing pass is needed.
module peer_relay_debt_scheduler #(
  parameter int MAX_PEERS = prds_pkg::MAX_PEERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  prds_in_if.sink                         in_ch,
  prds_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [prds_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [prds_pkg::CFG_DATA_W-1:0] cfg_data
);
  prds_pkg::dp_cmd_t cmd;
  prds_pkg::dp_sts_t sts;
  logic in_rdy;

  assign in_ch.ready = in_rdy;

  prds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_rdy   (in_rdy),
    .sts      (sts),
    .cmd      (cmd)
  );

  prds_dpath #(.MAX_PEERS(MAX_PEERS)) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .in_cmd       (in_ch.cmd),
    .in_addr      (in_ch.sender_addr),
    .in_port      (in_ch.sender_port),
    .in_chunk     (in_ch.seq_num),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_kind     (out_ch.kind),
    .out_addr     (out_ch.dest_addr),
    .out_port     (out_ch.dest_port),
    .out_chunk    (out_ch.fwd_chunk),
    .out_evicted  (out_ch.evicted),
    .out_was_data (out_ch.was_data),
    .out_full     (out_ch.table_full),
    .out_last     (out_ch.last)
  );
endmodule

// ===== hw/rtl/prds_ctrl.sv =====
// Sequencer of the peer relay debt scheduler: search, add, send, burst and compaction.
// Depends on prds_pkg for the command and status structs.
module prds_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_rdy,
  input  prds_pkg::dp_sts_t sts,
  output prds_pkg::dp_cmd_t cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_SRCH_RD, S_SRCH_CMP, S_REM_RD, S_REM_WR,
    S_SND_RD, S_SND_CHK, S_BST_CHK, S_BST_END, S_RR_CHK, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic ret_bst_r, ret_bst_nxt;

  assign in_rdy = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ret_bst_nxt = ret_bst_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.cmd == prds_pkg::CMD_DATA && sts.is_splitter) begin
          state_nxt = S_BST_CHK;
        end else if (sts.cmd == prds_pkg::CMD_DATA || sts.cmd == prds_pkg::CMD_HELLO ||
                     sts.cmd == prds_pkg::CMD_BYE) begin
          cmd.idx_clr = 1'b1;
          state_nxt = S_SRCH_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SRCH_RD: begin
        if (sts.idx_lt_cnt) begin
          cmd.rd_idx = 1'b1;
          state_nxt = S_SRCH_CMP;
        end else if (sts.cmd == prds_pkg::CMD_BYE) begin
          state_nxt = S_DONE;
        end else begin
          cmd.wr_add = 1'b1;
          state_nxt = (sts.cmd == prds_pkg::CMD_DATA) ? S_RR_CHK : S_DONE;
        end
      end
      S_SRCH_CMP: begin
        if (sts.match) begin
          if (sts.cmd == prds_pkg::CMD_DATA) begin
            cmd.wr_dec = 1'b1;
            state_nxt = S_RR_CHK;
          end else if (sts.cmd == prds_pkg::CMD_BYE) begin
            ret_bst_nxt = 1'b0;
            state_nxt = S_REM_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt = S_SRCH_RD;
        end
      end
      S_REM_RD: begin
        if (sts.idx1_lt_cnt) begin
          cmd.rd_idx1 = 1'b1;
          state_nxt = S_REM_WR;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt = ret_bst_r ? S_BST_CHK : S_DONE;
        end
      end
      S_REM_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt = S_REM_RD;
      end
      S_SND_RD: begin
        cmd.rd_idx = 1'b1;
        state_nxt = S_SND_CHK;
      end
      S_SND_CHK: begin
        if (sts.out_free) begin
          cmd.emit_send = 1'b1;
          cmd.feed_inc = 1'b1;
          if (sts.ev) begin
            state_nxt = S_REM_RD;
          end else begin
            cmd.wr_inc = 1'b1;
            state_nxt = ret_bst_r ? S_BST_CHK : S_DONE;
          end
        end
      end
      S_BST_CHK: begin
        if (sts.feed_burst) begin
          cmd.idx_feed = 1'b1;
          ret_bst_nxt = 1'b1;
          state_nxt = S_SND_RD;
        end else begin
          state_nxt = S_BST_END;
        end
      end
      S_BST_END: begin
        cmd.feed_clr = 1'b1;
        cmd.set_prev = 1'b1;
        state_nxt = S_RR_CHK;
      end
      S_RR_CHK: begin
        if (sts.rr_ok) begin
          cmd.idx_feed = 1'b1;
          ret_bst_nxt = 1'b0;
          state_nxt = S_SND_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit_done = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_bst_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_bst_r <= ret_bst_nxt;
    end
  end
endmodule

// ===== hw/rtl/prds_dpath.sv =====
// Datapath of the peer relay debt scheduler: peer table memory, counters,
// configuration registers and the result register. Depends on prds_pkg and the assertion macro header.
`include "peer_relay_debt_scheduler_assert.svh"
module prds_dpath #(
  parameter int MAX_PEERS = prds_pkg::MAX_PEERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [prds_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [prds_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [prds_pkg::CMD_W-1:0]      in_cmd,
  input  logic [prds_pkg::ADDR_W-1:0]     in_addr,
  input  logic [prds_pkg::PORT_W-1:0]     in_port,
  input  logic [prds_pkg::CHUNK_W-1:0]    in_chunk,
  input  prds_pkg::dp_cmd_t               cmd,
  output prds_pkg::dp_sts_t               sts,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic                            out_kind,
  output logic [prds_pkg::ADDR_W-1:0]     out_addr,
  output logic [prds_pkg::PORT_W-1:0]     out_port,
  output logic [prds_pkg::CHUNK_W-1:0]    out_chunk,
  output logic                            out_evicted,
  output logic                            out_was_data,
  output logic                            out_full,
  output logic                            out_last
);
  localparam int IW = $clog2(MAX_PEERS);
  localparam int CW = $clog2(MAX_PEERS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PEERS);

  prds_pkg::entry_t mem [MAX_PEERS];
  prds_pkg::entry_t rdata_r, wdata;

  logic [prds_pkg::ADDR_W-1:0] spl_addr_r;
  logic [prds_pkg::PORT_W-1:0] spl_port_r;
  logic [prds_pkg::MAXD_W-1:0] max_debt_r;

  logic [prds_pkg::CMD_W-1:0] cmd_r;
  logic [prds_pkg::ADDR_W-1:0] addr_r;
  logic [prds_pkg::PORT_W-1:0] port_r;
  logic [prds_pkg::CHUNK_W-1:0] chunk_r;
  logic full_r;

  logic [CW-1:0] cnt_r, feed_r, idx_r, idx1;
  logic [prds_pkg::CHUNK_W-1:0] prev_r;
  logic has_prev_r;

  logic out_valid_r, out_kind_r, out_ev_r, out_wd_r, out_full_r, out_last_r;
  logic [prds_pkg::ADDR_W-1:0] out_addr_r;
  logic [prds_pkg::PORT_W-1:0] out_port_r;
  logic [prds_pkg::CHUNK_W-1:0] out_chunk_r;

  logic signed [prds_pkg::DEBT_W:0] debt_inc;
  logic [prds_pkg::DEBT_W-1:0] debt_dec;
  logic can_add, wr_en;
  logic [IW-1:0] waddr, raddr;

  assign idx1 = idx_r + CW'(1);
  assign can_add = (cnt_r < CNT_MAX);
  assign debt_inc = $signed({rdata_r.debt[prds_pkg::DEBT_W-1], rdata_r.debt}) + 9'sd1;
  assign debt_dec = (rdata_r.debt == prds_pkg::DEBT_MIN) ? rdata_r.debt
                                                         : rdata_r.debt - 8'd1;

  assign sts.cmd = cmd_r;
  assign sts.is_splitter = (addr_r == spl_addr_r) && (port_r == spl_port_r);
  assign sts.match = (rdata_r.ip == addr_r) && (rdata_r.port == port_r);
  assign sts.idx_lt_cnt = (idx_r < cnt_r);
  assign sts.idx1_lt_cnt = (idx1 < cnt_r);
  assign sts.feed_burst = (feed_r != '0) && (feed_r < cnt_r);
  assign sts.rr_ok = has_prev_r && (feed_r < cnt_r);
  assign sts.ev = debt_inc > $signed({2'b00, max_debt_r});
  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    wdata = rdata_r;
    waddr = idx_r[IW-1:0];
    wr_en = cmd.wr_shift | cmd.wr_dec | cmd.wr_inc | (cmd.wr_add & can_add);
    if (cmd.wr_add) begin
      wdata.ip = addr_r;
      wdata.port = port_r;
      wdata.debt = '0;
      waddr = cnt_r[IW-1:0];
    end else if (cmd.wr_dec) begin
      wdata.debt = debt_dec;
    end else if (cmd.wr_inc) begin
      wdata.debt = debt_inc[prds_pkg::DEBT_W-1:0];
    end
    raddr = cmd.rd_idx1 ? idx1[IW-1:0] : idx_r[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_idx || cmd.rd_idx1) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r <= in_cmd;
      addr_r <= in_addr;
      port_r <= in_port;
      chunk_r <= in_chunk;
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_feed) begin
      idx_r <= feed_r;
    end else if (cmd.idx_inc) begin
      idx_r <= idx1;
    end
    if (cmd.emit_send) begin
      out_kind_r <= 1'b0;
      out_addr_r <= rdata_r.ip;
      out_port_r <= rdata_r.port;
      out_chunk_r <= prev_r;
      out_ev_r <= sts.ev;
      out_wd_r <= 1'b0;
      out_full_r <= 1'b0;
      out_last_r <= 1'b0;
    end else if (cmd.emit_done) begin
      out_kind_r <= 1'b1;
      out_addr_r <= '0;
      out_port_r <= '0;
      out_chunk_r <= chunk_r;
      out_ev_r <= 1'b0;
      out_wd_r <= (cmd_r == prds_pkg::CMD_DATA);
      out_full_r <= full_r;
      out_last_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spl_addr_r <= '0;
      spl_port_r <= '0;
      max_debt_r <= prds_pkg::MAX_DEBT_RST;
      cnt_r <= '0;
      feed_r <= '0;
      prev_r <= '0;
      has_prev_r <= 1'b0;
      full_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          prds_pkg::CFG_SPL_ADDR: spl_addr_r <= cfg_data;
          prds_pkg::CFG_SPL_PORT: spl_port_r <= cfg_data[prds_pkg::PORT_W-1:0];
          prds_pkg::CFG_MAX_DEBT: max_debt_r <= cfg_data[prds_pkg::MAXD_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load_in) begin
        full_r <= 1'b0;
      end else if (cmd.wr_add && !can_add) begin
        full_r <= 1'b1;
      end
      if (cmd.wr_add && can_add) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - CW'(1);
      end
      if (cmd.feed_clr) begin
        feed_r <= '0;
      end else if (cmd.feed_inc) begin
        feed_r <= feed_r + CW'(1);
      end
      if (cmd.set_prev) begin
        prev_r <= chunk_r;
        has_prev_r <= 1'b1;
      end
      if (cmd.emit_send || cmd.emit_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind = out_kind_r;
  assign out_addr = out_addr_r;
  assign out_port = out_port_r;
  assign out_chunk = out_chunk_r;
  assign out_evicted = out_ev_r;
  assign out_was_data = out_wd_r;
  assign out_full = out_full_r;
  assign out_last = out_last_r;

  `PRDS_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_MAX)
  `PRDS_ASSERT_NXT(a_full_set, clk, rst_n, cmd.wr_add && !can_add, full_r)
  `PRDS_ASSERT_NXT(a_send_out, clk, rst_n, cmd.emit_send, out_valid_r && !out_kind_r)
  `PRDS_ASSERT_NXT(a_done_out, clk, rst_n, cmd.emit_done, out_valid_r && out_last_r)
endmodule
